// File: rtl/lz_token_decoder_defines.svh
// Assertion helpers for the lz token decoder RTL.
`ifndef LZ_TOKEN_DECODER_DEFINES_SVH
`define LZ_TOKEN_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LZD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LZD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lzd_pkg.sv
package lzd_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned LEN_W        = 6;
   localparam int unsigned DIST_W       = 10;
   localparam int unsigned DIST_HI_LSB  = 6;
   localparam logic [7:0]  CTRL_LITERAL = 8'h00;
   localparam logic [5:0]  LEN_MASK     = 6'h3F;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              stream_last;
   } out_word_type;

endpackage

// File: rtl/lzd_window.sv
module lzd_window #(
   parameter int unsigned WINDOW_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [$clog2(WINDOW_DEPTH)-1:0]    rd_addr,
   output logic [lzd_pkg::BYTE_W-1:0]         rd_data,
   input  logic                               wr_en,
   input  logic [lzd_pkg::BYTE_W-1:0]         wr_data
);

   localparam int unsigned AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

   logic [lzd_pkg::BYTE_W-1:0] mem [WINDOW_DEPTH];
   logic [lzd_pkg::BYTE_W-1:0] mem_q_ff;

   logic [AW-1:0]              wr_pos_ff, wr_pos_in;
   logic                       full_ff, full_in;
   logic                       fwd_ff, fwd_in;
   logic                       zero_ff, zero_in;
   logic [lzd_pkg::BYTE_W-1:0] fwd_byte_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_pos_ff] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // entries are written in order from zero, so below wr_pos means written
   always_comb begin
      wr_pos_in = wr_pos_ff;
      full_in   = full_ff;
      if (wr_en) begin
         if (wr_pos_ff == LAST_ADDR) begin
            wr_pos_in = '0;
            full_in   = 1'b1;
         end else begin
            wr_pos_in = wr_pos_ff + AW'(1);
         end
      end
      fwd_in  = wr_en && (rd_addr == wr_pos_ff);
      zero_in = !full_ff && (rd_addr >= wr_pos_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         full_ff   <= 1'b0;
      end else begin
         wr_pos_ff <= wr_pos_in;
         full_ff   <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_ff      <= fwd_in;
         zero_ff     <= zero_in;
         fwd_byte_ff <= wr_data;
      end
   end

   always_comb begin
      priority if (fwd_ff) begin
         rd_data = fwd_byte_ff;
      end else if (zero_ff) begin
         rd_data = '0;
      end else begin
         rd_data = mem_q_ff;
      end
   end

endmodule

// File: rtl/lzd_out_buf.sv
module lzd_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lzd_pkg::out_word_type push_word,
   input  logic                  pop,
   output logic                  head_valid,
   output lzd_pkg::out_word_type head_word,
   output logic [1:0]            level
);

   lzd_pkg::out_word_type slot [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         slot[wr_ptr_ff] <= push_word;
      end
   end

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   assign head_valid = (count_ff != 2'd0);
   assign head_word  = slot[rd_ptr_ff];
   assign level      = count_ff;

endmodule

// File: rtl/lz_token_decoder.sv
// channel | dir | tdata                                | tlast       | tuser
// req     | in  | [7:0] token_ctrl, [15:8] token_data  | final_token | -
// rsp     | out | [7:0] out_byte                       | run_last    | stream_last
//
// A token holds the input while it is taken and issued: one issue per cycle
// while the output buffer has room, L issues for a match of length L, or one for a literal.
// Each word passes from the issue registers through the window read and stage 1
// into the buffer, one byte per cycle while it has room: one window read per match byte, one window write per byte.
// Reset clears the write position and fill flag, so unwritten entries read as
// zero. rsp stalls hold up issue through a two-word buffer.
`include "lz_token_decoder_defines.svh"

module lz_token_decoder #(
   parameter int unsigned WINDOW_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] token_ctrl, [15:8] token_data
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] stream_last
);

   localparam int unsigned AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

   logic [7:0]                 tok_ctrl;
   logic [7:0]                 tok_data;
   logic                       tok_lit;
   logic [lzd_pkg::DIST_W-1:0] tok_dist;
   logic [AW:0]                start_sum;
   logic [AW-1:0]              start_addr;
   logic                       req_accept;

   logic                       busy_ff, busy_in;
   logic                       lit_ff, lit_in;
   logic                       fin_ff, fin_in;
   logic [7:0]                 lit_byte_ff, lit_byte_in;
   logic [lzd_pkg::LEN_W-1:0]  remain_ff, remain_in;
   logic [AW-1:0]              rd_addr_ff, rd_addr_in;
   logic [AW-1:0]              iss_pos_ff, iss_pos_in;

   logic                       s1_valid_ff;
   logic                       s1_lit_ff, s1_last_ff, s1_fin_ff;
   logic [7:0]                 s1_lit_byte_ff;

   logic                       issue;
   logic [2:0]                 occupancy;
   logic [7:0]                 win_rd_data;
   logic [7:0]                 s1_byte;
   logic                       rsp_pop;
   logic [1:0]                 buf_level;
   lzd_pkg::out_word_type      push_word, head_word;

   assign tok_ctrl   = req_tdata[7:0];
   assign tok_data   = req_tdata[15:8];
   assign tok_lit    = (tok_ctrl == lzd_pkg::CTRL_LITERAL);
   assign tok_dist   = {tok_ctrl[7:lzd_pkg::DIST_HI_LSB], tok_data};
   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      start_sum = {1'b0, iss_pos_ff} + (AW+1)'(WINDOW_DEPTH - 1) - (AW+1)'(tok_dist);
      if (start_sum >= (AW+1)'(WINDOW_DEPTH)) begin
         start_addr = AW'(start_sum - (AW+1)'(WINDOW_DEPTH));
      end else begin
         start_addr = AW'(start_sum);
      end
   end

   // issue only when the output buffer has room for the word it produces
   assign rsp_pop   = rsp_tvalid && rsp_tready;
   assign occupancy = 3'(buf_level) + 3'(s1_valid_ff) - 3'(rsp_pop);
   assign issue     = busy_ff && (occupancy < 3'd2);

   always_comb begin
      busy_in     = busy_ff;
      lit_in      = lit_ff;
      fin_in      = fin_ff;
      lit_byte_in = lit_byte_ff;
      remain_in   = remain_ff;
      rd_addr_in  = rd_addr_ff;
      iss_pos_in  = iss_pos_ff;
      if (req_accept) begin
         busy_in     = 1'b1;
         lit_in      = tok_lit;
         fin_in      = req_tlast;
         lit_byte_in = tok_data;
         remain_in   = tok_lit ? '0 : (tok_ctrl[5:0] & lzd_pkg::LEN_MASK);
         rd_addr_in  = start_addr;
      end else if (issue) begin
         remain_in  = remain_ff - lzd_pkg::LEN_W'(1);
         busy_in    = (remain_ff != '0);
         rd_addr_in = (rd_addr_ff == LAST_ADDR) ? '0 : rd_addr_ff + AW'(1);
         iss_pos_in = (iss_pos_ff == LAST_ADDR) ? '0 : iss_pos_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         iss_pos_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         iss_pos_ff  <= iss_pos_in;
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      lit_ff         <= lit_in;
      fin_ff         <= fin_in;
      lit_byte_ff    <= lit_byte_in;
      remain_ff      <= remain_in;
      rd_addr_ff     <= rd_addr_in;
      s1_lit_ff      <= lit_ff;
      s1_last_ff     <= (remain_ff == '0);
      s1_fin_ff      <= fin_ff;
      s1_lit_byte_ff <= lit_byte_ff;
   end

   lzd_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (issue && !lit_ff),
      .rd_addr (rd_addr_ff),
      .rd_data (win_rd_data),
      .wr_en   (s1_valid_ff),
      .wr_data (s1_byte)
   );

   assign s1_byte = s1_lit_ff ? s1_lit_byte_ff : win_rd_data;

   always_comb begin
      push_word.out_byte    = s1_byte;
      push_word.run_last    = s1_last_ff;
      push_word.stream_last = s1_last_ff && s1_fin_ff;
   end

   lzd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_valid_ff),
      .push_word  (push_word),
      .pop        (rsp_pop),
      .head_valid (rsp_tvalid),
      .head_word  (head_word),
      .level      (buf_level)
   );

   assign rsp_tdata = head_word.out_byte;
   assign rsp_tlast = head_word.run_last;
   assign rsp_tuser = head_word.stream_last;

   `LZD_ASSERT_IMP(a_buf_no_overflow, (buf_level == 2'd2) && !rsp_pop, !s1_valid_ff, "output buffer overflow")
   `LZD_ASSERT_NXT(a_accept_starts_run, req_accept, busy_ff, "accepted token did not start")
   `LZD_ASSERT_IMP(a_stream_last_ends_run, rsp_tvalid && rsp_tuser, rsp_tlast, "stream end without run end")

endmodule

// File: tb/lz_token_decoder_tb.sv
`timescale 1ns / 1ps

module lz_token_decoder_tb;

   localparam int HIST_DEPTH = 1024;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] token_ctrl, [15:8] token_data
   logic        req_tlast = 1'b0; // final_token
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] out_byte
   logic        rsp_tlast;        // run_last
   logic        rsp_tuser;        // [0] stream_last

   logic [lzd_pkg::BYTE_W-1:0] window [HIST_DEPTH];
   int                         wr_pos;
   int                         fill_count;
   lzd_pkg::out_word_type      expected_bytes [$];
   lzd_pkg::out_word_type      want;
   int                         error_count = 0;
   int                         req_idle_pct = 0;
   int                         rsp_stall_pct = 0;

   lz_token_decoder #(.WINDOW_DEPTH(HIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void append_byte(logic [7:0] value, logic last, logic fin);
      lzd_pkg::out_word_type w;
      window[wr_pos] = value;
      wr_pos = (wr_pos + 1) % HIST_DEPTH;
      if (fill_count < HIST_DEPTH) fill_count++;
      w.out_byte = value;
      w.run_last = last;
      w.stream_last = last & fin;
      expected_bytes.push_back(w);
   endfunction

   function automatic void expand_token(logic [7:0] ctrl, logic [7:0] data, logic fin);
      int back_ref;
      int len;
      int rd;
      if (ctrl == lzd_pkg::CTRL_LITERAL) begin
         append_byte(data, 1'b1, fin);
      end else begin
         back_ref = int'({ctrl[7:lzd_pkg::DIST_HI_LSB], data});
         len = int'(ctrl[lzd_pkg::LEN_W-1:0] & lzd_pkg::LEN_MASK) + 1;
         rd = (wr_pos + HIST_DEPTH - 1 - back_ref) % HIST_DEPTH;
         for (int i = 0; i < len; i++)
            append_byte(window[(rd + i) % HIST_DEPTH], i == len - 1, fin);
      end
   endfunction

   task automatic send_token(input logic [7:0] ctrl, input logic [7:0] data,
                             input logic fin);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {data, ctrl};
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expand_token(ctrl, data, fin);
   endtask

   // result word checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected word: out_byte %0h run_last %0b stream_last %0b",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               $error("out_byte: expected %0h, actual %0h", want.out_byte, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.run_last) begin
               $error("run_last: expected %0b, actual %0b", want.run_last, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser !== want.stream_last) begin
               $error("stream_last: expected %0b, actual %0b",
                      want.stream_last, rsp_tuser);
               error_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // window still clear: far references read zero, incl. read of the slot being written
   task automatic test_unwritten_reads();
      send_token(8'hFF, 8'hFF, 1'b0);
      send_token(8'h80, 8'h10, 1'b0);
      send_token(8'h40, 8'h00, 1'b0);
   endtask

   task automatic test_literals();
      send_token(lzd_pkg::CTRL_LITERAL, 8'h00, 1'b0);
      send_token(lzd_pkg::CTRL_LITERAL, 8'hFF, 1'b0);
      send_token(lzd_pkg::CTRL_LITERAL, 8'h55, 1'b0);
      send_token(lzd_pkg::CTRL_LITERAL, 8'hAA, 1'b0);
      send_token(lzd_pkg::CTRL_LITERAL, 8'h3C, 1'b0);
   endtask

   task automatic test_matches();
      send_token(8'h3F, 8'h00, 1'b0);   // overlapping, repeats last byte
      send_token(8'h09, 8'h03, 1'b0);   // overlapping, period four
      send_token(8'h01, 8'h45, 1'b0);
      send_token(8'h40, 8'h00, 1'b0);   // beyond written bytes, wraps
      send_token(8'hC5, 8'hFF, 1'b0);   // largest distance
      send_token(8'h3F, 8'h7F, 1'b0);
   endtask

   task automatic test_stream_ends();
      send_token(lzd_pkg::CTRL_LITERAL, 8'h81, 1'b1);
      send_token(8'h04, 8'h00, 1'b1);
      send_token(8'h02, 8'h06, 1'b0);   // continues after the final token
      send_token(lzd_pkg::CTRL_LITERAL, 8'h18, 1'b1);
   endtask

   task automatic test_random_tokens(input int count, input int idle_pct,
                                     input int stall_pct);
      logic [7:0] ctrl;
      logic [7:0] data;
      logic [9:0] back_ref;
      logic [5:0] len_m1;
      int         pick;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         pick = int'($urandom_range(99));
         data = 8'($urandom_range(255));
         if (pick < 40 || fill_count == 0) begin
            ctrl = lzd_pkg::CTRL_LITERAL;
         end else if (pick < 88) begin
            back_ref = 10'($urandom_range(fill_count - 1));
            len_m1 = ($urandom_range(4) == 0) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(15));
            ctrl = {back_ref[9:8], len_m1};
            if (ctrl == lzd_pkg::CTRL_LITERAL) ctrl = 8'h01;
            data = back_ref[7:0];
         end else begin
            ctrl = 8'($urandom_range(255));
         end
         send_token(ctrl, data, $urandom_range(19) == 0);
      end
   endtask

   initial begin
      for (int i = 0; i < HIST_DEPTH; i++) window[i] = '0;
      wr_pos = 0;
      fill_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_unwritten_reads();
      test_literals();
      test_matches();
      test_stream_ends();
      test_random_tokens(100, 0, 0);
      test_random_tokens(100, 64, 0);
      test_random_tokens(100, 0, 64);
      test_random_tokens(100, 18, 18);
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
